@@ rtl/mts_pkg.sv @@
package mts_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int DATA_W        = 32;
	localparam int CMD_W         = 2;
	localparam int STATUS_W      = 2;

	// command codes; any code with bit 1 set reads as a peek
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam int               CMD_PEEK_BIT = 1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic take;    // accept that completes in this cycle
		logic defer;   // pop accept that needs the entry below from memory
		logic finish;  // memory data is back, load the new top
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic single;
		logic out_busy;
	} dp_stat_t;

endpackage

@@ rtl/mts_cmd_if.sv @@
interface mts_cmd_if;
	import mts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);

endinterface

@@ rtl/mts_rsp_if.sv @@
interface mts_rsp_if #(
	parameter int CW = 7
);
	import mts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	logic signed [DATA_W-1:0] minimum;
	logic [CW-1:0]            fill_count;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, output data, output minimum, output fill_count,
		output status, input ready);
	modport sink   (input valid, input data, input minimum, input fill_count,
		input status, output ready);

endinterface

@@ rtl/mts_ram.sv @@
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/mts_ctrl.sv @@
module mts_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [mts_pkg::CMD_W-1:0] in_command,
	input  mts_pkg::dp_stat_t        stat,
	output logic                     in_ready,
	output mts_pkg::ctl_t            ctl
);
	import mts_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_REFILL
	} state_t;

	state_t state_q;
	logic   accept;
	logic   pop_refill;

	// a pop that leaves entries behind must fetch the new top from memory
	assign pop_refill = (in_command == CMD_POP) && !stat.empty && !stat.single;
	assign in_ready   = (state_q == S_IDLE) && !stat.out_busy;
	assign accept     = in_ready && in_valid;

	assign ctl.take   = accept && !pop_refill;
	assign ctl.defer  = accept && pop_refill;
	assign ctl.finish = (state_q == S_REFILL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.defer) begin
						state_q <= S_REFILL;
					end
				end
				S_REFILL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/mts_dp.sv @@
module mts_dp #(
	parameter int DEPTH = mts_pkg::DEPTH_DEFAULT,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mts_pkg::CMD_W-1:0]        command,
	input  logic signed [mts_pkg::DATA_W-1:0] value,
	input  mts_pkg::ctl_t                    ctl,
	input  logic                             out_ready,
	output mts_pkg::dp_stat_t                stat,
	output logic                             out_valid,
	output logic signed [mts_pkg::DATA_W-1:0] data,
	output logic signed [mts_pkg::DATA_W-1:0] minimum,
	output logic [CW-1:0]                    fill_count,
	output logic [mts_pkg::STATUS_W-1:0]     status
);
	import mts_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [CW-1:0]            count_q;
	logic                     valid_q;
	logic signed [DATA_W-1:0] top_val_q;
	logic signed [DATA_W-1:0] top_min_q;
	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] min_q;
	logic [CW-1:0]            fill_q;
	status_t                  status_q;

	logic                     full;
	logic                     empty;
	logic                     is_push;
	logic                     is_pop;
	logic                     wr_en;
	logic signed [DATA_W-1:0] push_min;
	logic [CW-1:0]            count_inc;
	logic [CW-1:0]            count_dec;
	logic [CW-1:0]            below_idx;
	logic [DATA_W-1:0]        ram_val;
	logic [DATA_W-1:0]        ram_min;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign is_push   = (command == CMD_PUSH);
	assign is_pop    = (command == CMD_POP);
	assign count_inc = count_q + CW'(1);
	assign count_dec = count_q - CW'(1);
	assign below_idx = count_q - CW'(2);
	assign push_min  = (!empty && (top_min_q < value)) ? top_min_q : value;
	assign wr_en     = ctl.take && is_push && !full;

	assign stat.empty    = empty;
	assign stat.single   = (count_q == CW'(1));
	assign stat.out_busy = valid_q && !out_ready;

	mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (value),
		.rd_en   (ctl.defer),
		.rd_addr (below_idx[AW-1:0]),
		.rd_data (ram_val)
	);

	mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_min_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (push_min),
		.rd_en   (ctl.defer),
		.rd_addr (below_idx[AW-1:0]),
		.rd_data (ram_min)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_inc;
			end else if ((ctl.take && is_pop && !empty) || ctl.defer) begin
				count_q <= count_dec;
			end
			if (ctl.take || ctl.finish) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			if (is_push) begin
				if (full) begin
					data_q   <= '0;
					min_q    <= top_min_q;
					fill_q   <= count_q;
					status_q <= ST_OVERFLOW;
				end else begin
					data_q    <= value;
					min_q     <= push_min;
					fill_q    <= count_inc;
					status_q  <= ST_OK;
					top_val_q <= value;
					top_min_q <= push_min;
				end
			end else if (empty) begin
				data_q   <= '0;
				min_q    <= '0;
				fill_q   <= '0;
				status_q <= ST_UNDERFLOW;
			end else if (is_pop) begin
				// last entry leaves
				data_q   <= top_val_q;
				min_q    <= '0;
				fill_q   <= '0;
				status_q <= ST_OK;
			end else begin
				data_q   <= top_val_q;
				min_q    <= top_min_q;
				fill_q   <= count_q;
				status_q <= ST_OK;
			end
		end
		if (ctl.defer) begin
			data_q   <= top_val_q;
			fill_q   <= count_dec;
			status_q <= ST_OK;
		end
		if (ctl.finish) begin
			top_val_q <= ram_val;
			top_min_q <= ram_min;
			min_q     <= ram_min;
		end
	end

	assign out_valid  = valid_q;
	assign data       = data_q;
	assign minimum    = min_q;
	assign fill_count = fill_q;
	assign status     = status_q;

endmodule

@@ rtl/min_tracking_stack.sv @@
// channel | dir | transaction carries
// --------+-----+------------------------------------------------
// cmd     | in  | command (push, pop, peek), value to push
// rsp     | out | data, minimum, fill_count, status
//
// push, peek, errors and a pop of the last entry go from accept straight to the
// output register; a pop that leaves entries first passes through the refill
// state, waiting on the registered read of the entry below from the memories.
// cmd.ready is low in the refill state and while a result is stalled.
// arst_n clears the entry count and the output valid; memories are not cleared.
// a result held in rsp keeps its payload stable until rsp.ready.
module min_tracking_stack #(
	parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	mts_cmd_if.sink   cmd,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	// fill count holds zero up to DEPTH
	localparam int CW = $clog2(DEPTH + 1);

	ctl_t     ctl;
	dp_stat_t stat;

	// sequencer: decides whether an accepted pop needs a memory refill
	mts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_command (cmd.command),
		.stat       (stat),
		.in_ready   (cmd.ready),
		.ctl        (ctl)
	);

	// top value and minimum in registers, entries in memory, result register
	mts_dp #(.DEPTH(DEPTH), .CW(CW)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (cmd.command),
		.value      (cmd.value),
		.ctl        (ctl),
		.out_ready  (rsp.ready),
		.stat       (stat),
		.out_valid  (rsp.valid),
		.data       (rsp.data),
		.minimum    (rsp.minimum),
		.fill_count (rsp.fill_count),
		.status     (rsp.status)
	);

endmodule

@@ rtl/mts_chk.sv @@
module mts_chk #(
	parameter int DEPTH = mts_pkg::DEPTH_DEFAULT,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [mts_pkg::DATA_W-1:0] data,
	input logic signed [mts_pkg::DATA_W-1:0] minimum,
	input logic [CW-1:0]                    fill_count,
	input logic [mts_pkg::STATUS_W-1:0]     status
);
	import mts_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data) && $stable(minimum)
			&& $stable(fill_count) && $stable(status))
		else $error("stalled result changed");

	a_under: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNDERFLOW) |->
			(data == '0) && (minimum == '0) && (fill_count == '0))
		else $error("underflow result not cleared");

	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OVERFLOW) |->
			(fill_count == CW'(DEPTH)) && (data == '0))
		else $error("overflow while not full");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) && (fill_count == '0) |-> (minimum == '0))
		else $error("empty stack reports a minimum");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_count <= CW'(DEPTH)) && (status != 2'd3))
		else $error("fill count or status out of range");

endmodule

bind min_tracking_stack mts_chk #(.DEPTH(DEPTH), .CW(CW)) u_mts_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.data       (rsp.data),
	.minimum    (rsp.minimum),
	.fill_count (rsp.fill_count),
	.status     (rsp.status)
);
